### rtl/apoc_pkg.sv
// Shared types and constants of the accelerometer pitch offset calibrator.
package apoc_pkg;

    localparam int PITCH_LIMIT = 23040;
    localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;

    typedef logic signed [47:0] cval_t;

    function automatic logic [22:0] atan_deg(input logic [4:0] i);
        case (i)
            5'd0: atan_deg = 23'd2949120;
            5'd1: atan_deg = 23'd1740967;
            5'd2: atan_deg = 23'd919879;
            5'd3: atan_deg = 23'd466945;
            5'd4: atan_deg = 23'd234379;
            5'd5: atan_deg = 23'd117304;
            5'd6: atan_deg = 23'd58666;
            5'd7: atan_deg = 23'd29335;
            5'd8: atan_deg = 23'd14668;
            5'd9: atan_deg = 23'd7334;
            5'd10: atan_deg = 23'd3667;
            5'd11: atan_deg = 23'd1833;
            5'd12: atan_deg = 23'd917;
            5'd13: atan_deg = 23'd458;
            5'd14: atan_deg = 23'd229;
            5'd15: atan_deg = 23'd115;
            5'd16: atan_deg = 23'd57;
            5'd17: atan_deg = 23'd29;
            5'd18: atan_deg = 23'd14;
            5'd19: atan_deg = 23'd7;
            5'd20: atan_deg = 23'd4;
            5'd21: atan_deg = 23'd2;
            5'd22: atan_deg = 23'd1;
            default: atan_deg = 23'd0;
        endcase
    endfunction

endpackage

### rtl/accel_pitch_offset_calibrator_top.sv
// Top level of the accelerometer pitch offset calibrator.
// On a run's last sample two restoring divisions form the means before the result is offered.
// The shared CORDIC shift-add unit and the divider handle one sample at a time, so no new
// sample is accepted before the last one's result has been taken.
// Input ready is low while busy and while a result waits; reset (aresetn low, synchronous)
// clears the sample counter, sums, held means, the stored sample and the output valid flag.
module accel_pitch_offset_calibrator_top #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // accel_x, accel_y, accel_z, gyro_y from the lowest bit up, zero filled.
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // read_ok.
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // pitch, pitch_offset, gyro_offset from the lowest bit up.
    output logic [55:0]              m_tdata,
    // calibration_done.
    output logic                     m_tuser,
    input  logic                     cfg_we,
    input  logic [0:0]               cfg_index,
    input  logic [14:0]              cfg_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int GUARD = 30 - SB;
    localparam int NS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam logic [4:0] LAST_STEP = 5'(NS - 1);
    localparam logic [0:0] REG_AVG = 1'b0;
    localparam logic [0:0] REG_DISC = 1'b1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAG = 3'd1;
    localparam logic [2:0] ST_GAIN = 3'd2;
    localparam logic [2:0] ST_ANG = 3'd3;
    localparam logic [2:0] ST_ACC = 3'd4;
    localparam logic [2:0] ST_DIV = 3'd5;
    localparam logic [2:0] ST_OUT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [14:0] avg_reg;
    logic [9:0] disc_reg;
    logic signed [SB-1:0] ax_reg, ay_reg, az_reg, gy_reg;
    logic [15:0] cnt_reg;
    logic [31:0] psum_reg, gsum_reg;
    logic signed [15:0] hpm_reg;
    logic signed [23:0] hgm_reg;
    apoc_pkg::cval_t x_reg, y_reg;
    logic signed [24:0] ang_reg;
    logic [4:0] step_reg;
    logic signed [15:0] pitch_reg;
    logic done_reg;
    logic [5:0] dcnt_reg;
    logic [41:0] q_reg;
    logic [15:0] rem_reg;
    logic dneg_reg, dsel_reg;
    logic [41:0] pmag_reg;
    logic out_full_reg;

    apoc_pkg::cval_t xs, ys, xn, yn;
    logic [16:0] end_w;
    logic sum_en, done_w;
    logic [15:0] rem_sh;
    logic [16:0] rem_try;
    logic [63:0] gain_prod;
    logic signed [25:0] rnd;
    logic signed [24:0] rnd_sh;
    logic signed [15:0] pitch_w;
    logic [41:0] q_fin;
    logic signed [42:0] qs;
    logic signed [31:0] psum_s, gsum_s;

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign xn = y_reg[47] ? x_reg - ys : x_reg + ys;
    assign yn = y_reg[47] ? y_reg + xs : y_reg - xs;
    assign end_w = {7'd0, disc_reg} + {2'd0, avg_reg};
    assign sum_en = ({1'b0, cnt_reg} > {7'd0, disc_reg}) && ({1'b0, cnt_reg} <= end_w);
    assign done_w = {1'b0, cnt_reg} >= end_w;
    assign gain_prod = x_reg[31:0] * apoc_pkg::INV_GAIN_Q30;
    assign rnd = 26'(ang_reg) + 26'sd128;
    assign rnd_sh = 25'(rnd >>> 8);
    assign pitch_w = (rnd_sh > 25'(apoc_pkg::PITCH_LIMIT)) ? 16'(apoc_pkg::PITCH_LIMIT)
                   : (rnd_sh < -25'(apoc_pkg::PITCH_LIMIT)) ? -16'(apoc_pkg::PITCH_LIMIT)
                   : 16'(rnd_sh);
    assign rem_sh = {rem_reg[14:0], pmag_reg[41]};
    assign rem_try = {1'b0, rem_sh} - {2'b0, avg_reg};
    assign q_fin = {q_reg[40:0], ~rem_try[16]};
    assign qs = dneg_reg ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
    assign psum_s = $signed(psum_reg);
    assign gsum_s = $signed(gsum_reg);

    assign s_tready = (state_reg == ST_IDLE) && !out_full_reg;
    assign m_tvalid = out_full_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready) state_next = ST_MAG;
            ST_MAG:  if (step_reg == LAST_STEP) state_next = ST_GAIN;
            ST_GAIN: state_next = ST_ANG;
            ST_ANG:  if (step_reg == LAST_STEP || (x_reg == 0 && y_reg == 0))
                         state_next = ST_ACC;
            ST_ACC:  state_next = done_w ? ST_DIV : ST_OUT;
            ST_DIV:  if (dcnt_reg == 6'd41 && dsel_reg) state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            avg_reg <= 15'd256;
            disc_reg <= 10'd100;
            ax_reg <= '0; ay_reg <= '0; az_reg <= '0; gy_reg <= '0;
            cnt_reg <= '0;
            psum_reg <= '0;
            gsum_reg <= '0;
            hpm_reg <= '0;
            hgm_reg <= '0;
            out_full_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_AVG:  avg_reg <= cfg_data;
                    REG_DISC: disc_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) out_full_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    step_reg <= '0;
                    if (s_tvalid && s_tready && s_tuser) begin
                        ax_reg <= s_tdata[SB-1:0];
                        ay_reg <= s_tdata[2*SB-1:SB];
                        az_reg <= s_tdata[3*SB-1:2*SB];
                        gy_reg <= s_tdata[4*SB-1:3*SB];
                        x_reg <= 48'(s_tdata[3*SB-1] ? -48'($signed(s_tdata[3*SB-1:2*SB]))
                                 : 48'($signed(s_tdata[3*SB-1:2*SB]))) <<< GUARD;
                        y_reg <= 48'(s_tdata[2*SB-1] ? -48'($signed(s_tdata[2*SB-1:SB]))
                                 : 48'($signed(s_tdata[2*SB-1:SB]))) <<< GUARD;
                    end else begin
                        x_reg <= 48'(az_reg[SB-1] ? -48'(az_reg) : 48'(az_reg)) <<< GUARD;
                        y_reg <= 48'(ay_reg[SB-1] ? -48'(ay_reg) : 48'(ay_reg)) <<< GUARD;
                    end
                end
                ST_MAG: begin
                    x_reg <= xn;
                    y_reg <= yn;
                    step_reg <= step_reg + 5'd1;
                end
                ST_GAIN: begin
                    x_reg <= 48'((gain_prod + 64'(1 << 29)) >> 30);
                    y_reg <= 48'(ax_reg) <<< GUARD;
                    ang_reg <= '0;
                    step_reg <= '0;
                end
                ST_ANG: begin
                    if (!(x_reg == 0 && y_reg == 0 && step_reg == 0)) begin
                        x_reg <= xn;
                        y_reg <= yn;
                        ang_reg <= y_reg[47] ? ang_reg - 25'(apoc_pkg::atan_deg(step_reg))
                                             : ang_reg + 25'(apoc_pkg::atan_deg(step_reg));
                    end
                    step_reg <= step_reg + 5'd1;
                end
                ST_ACC: begin
                    pitch_reg <= pitch_w;
                    done_reg <= done_w;
                    dcnt_reg <= '0;
                    dsel_reg <= 1'b0;
                    rem_reg <= '0;
                    q_reg <= '0;
                    if (sum_en) begin
                        psum_reg <= psum_reg + 32'(pitch_w);
                        gsum_reg <= gsum_reg + 32'(gy_reg);
                    end
                    if (done_w) begin
                        cnt_reg <= '0;
                        dneg_reg <= sum_en ? ((psum_s + 32'(pitch_w)) < 0) : (psum_s < 0);
                        pmag_reg <= 42'(sum_en ? ((psum_s + 32'(pitch_w)) < 0
                            ? -(psum_s + 32'(pitch_w)) : psum_s + 32'(pitch_w))
                            : (psum_s < 0 ? -psum_s : psum_s));
                    end else begin
                        cnt_reg <= cnt_reg + 16'd1;
                    end
                end
                ST_DIV: begin
                    if (dcnt_reg == 6'd41) begin
                        dcnt_reg <= '0;
                        rem_reg <= '0;
                        q_reg <= '0;
                        if (!dsel_reg) begin
                            dsel_reg <= 1'b1;
                            hpm_reg <= (avg_reg == 0) ? 16'sd0
                                : (qs > 43'(apoc_pkg::PITCH_LIMIT)) ? 16'(apoc_pkg::PITCH_LIMIT)
                                : (qs < -43'(apoc_pkg::PITCH_LIMIT)) ? -16'(apoc_pkg::PITCH_LIMIT)
                                : 16'(qs);
                            dneg_reg <= gsum_s < 0;
                            pmag_reg <= 42'(gsum_s < 0 ? -33'(gsum_s) : 33'(gsum_s)) << 8;
                        end else begin
                            hgm_reg <= (avg_reg == 0) ? 24'sd0
                                : (qs > 43'sd8388607) ? 24'sd8388607
                                : (qs < -43'sd8388608) ? 24'sh800000
                                : 24'(qs);
                        end
                    end else begin
                        if (rem_try[16]) rem_reg <= rem_sh;
                        else rem_reg <= rem_try[15:0];
                        q_reg <= q_fin;
                        pmag_reg <= {pmag_reg[40:0], 1'b0};
                        dcnt_reg <= dcnt_reg + 6'd1;
                    end
                end
                ST_OUT: begin
                    out_full_reg <= 1'b1;
                    if (done_reg) begin
                        psum_reg <= '0;
                        gsum_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tdata = {hgm_reg, hpm_reg, pitch_reg};
    assign m_tuser = done_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
    a_div_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> done_reg) else $error("division without done");

endmodule

### verif/testbench.sv
// Self-checking testbench for the accelerometer pitch offset calibrator top level.
`timescale 1ns / 100ps

module testbench;

    typedef enum logic [0:0] {
        REG_AVERAGE_COUNT = 1'b0,
        REG_DISCARD_COUNT = 1'b1
    } cal_reg_e;

    typedef struct {
        logic signed [15:0] pitch;
        logic               done;
        logic signed [15:0] pitch_offset;
        logic signed [23:0] gyro_offset;
    } cal_result_t;

    localparam int PITCH_MAX = 23040;
    localparam int GUARD_BITS = 14;
    localparam int STEPS = 16;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [14:0] cfg_data;

    cal_result_t expected_q[$];
    int          fail_count;
    int          idle_pct;
    int          stall_pct;

    // Calibrator state as the testbench tracks it.
    int unsigned avg_len;
    int unsigned warmup_len;
    int          good_ax, good_ay, good_az, good_gy;
    int unsigned run_pos;
    int          pitch_acc;
    int          gyro_acc;
    int          mean_pitch;
    int          mean_gyro;

    longint atan_q16 [STEPS] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                 58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                 229, 115};

    accel_pitch_offset_calibrator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("accel_pitch_offset_calibrator_top verification failed");
        $finish;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int pitch_deg(int ax, int ay, int az);
        longint x, y, nx, ang;
        x = longint'(az < 0 ? -az : az) * (longint'(1) << GUARD_BITS);
        y = longint'(ay < 0 ? -ay : ay) * (longint'(1) << GUARD_BITS);
        ang = 0;
        for (int i = 0; i < STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
            end
            x = nx;
        end
        x = (x * longint'(652032874) + (longint'(1) << 29)) >>> 30;
        y = longint'(ax) * (longint'(1) << GUARD_BITS);
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                ang += atan_q16[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                ang -= atan_q16[i];
            end
            x = nx;
        end
        return int'(clamp((ang + 128) >>> 8, -PITCH_MAX, PITCH_MAX));
    endfunction

    function automatic cal_result_t predict_sample(logic [63:0] d, logic ok);
        cal_result_t r;
        int p;
        int unsigned run_end;
        if (ok) begin
            good_ax = int'($signed(d[15:0]));
            good_ay = int'($signed(d[31:16]));
            good_az = int'($signed(d[47:32]));
            good_gy = int'($signed(d[63:48]));
        end
        p = pitch_deg(good_ax, good_ay, good_az);
        run_end = warmup_len + avg_len;
        if (run_pos > warmup_len && run_pos <= run_end) begin
            pitch_acc += p;
            gyro_acc += good_gy;
        end
        r.done = run_pos >= run_end;
        if (r.done) begin
            mean_pitch = (avg_len == 0) ? 0 :
                int'(clamp(longint'(pitch_acc) / longint'(avg_len), -PITCH_MAX, PITCH_MAX));
            mean_gyro = (avg_len == 0) ? 0 :
                int'(clamp(longint'(gyro_acc) * 256 / longint'(avg_len), -8388608, 8388607));
            pitch_acc = 0;
            gyro_acc = 0;
            run_pos = 0;
        end else begin
            run_pos = (run_pos + 1) & 32'hFFFF;
        end
        r.pitch = p[15:0];
        r.pitch_offset = mean_pitch[15:0];
        r.gyro_offset = mean_gyro[23:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cal_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $display("%t: unexpected result transfer, actual %h done %b",
                         $realtime, m_tdata, m_tuser);
                fail_count++;
            end else begin
                e = expected_q.pop_front();
                if (m_tdata[15:0] !== e.pitch) begin
                    $display("%t: pitch expected %0d actual %0d", $realtime,
                             e.pitch, $signed(m_tdata[15:0]));
                    fail_count++;
                end
                if (m_tuser !== e.done) begin
                    $display("%t: calibration_done expected %b actual %b", $realtime,
                             e.done, m_tuser);
                    fail_count++;
                end
                if (m_tdata[31:16] !== e.pitch_offset) begin
                    $display("%t: pitch_offset expected %0d actual %0d", $realtime,
                             e.pitch_offset, $signed(m_tdata[31:16]));
                    fail_count++;
                end
                if (m_tdata[55:32] !== e.gyro_offset) begin
                    $display("%t: gyro_offset expected %0d actual %0d", $realtime,
                             e.gyro_offset, $signed(m_tdata[55:32]));
                    fail_count++;
                end
            end
        end
    end

    task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [15:0] gy, logic ok);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {gy, az, ay, ax};
        s_tuser <= ok;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(predict_sample({gy, az, ay, ax}, ok));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(cal_reg_e idx, logic [14:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_AVERAGE_COUNT) avg_len = 32'(value);
        else warmup_len = 32'(value & 15'h3FF);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(int count);
        for (int n = 0; n < count; n++)
            send_sample(pick_value(), pick_value(), pick_value(), pick_value(),
                        $urandom_range(99) < 85);
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        send_sample(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b0);
        write_reg(REG_AVERAGE_COUNT, 15'd0);
        write_reg(REG_DISCARD_COUNT, 15'd0);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 1'b1);
        send_sample(16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 1'b1);
        send_sample(16'h8000, 16'h0000, 16'h0000, 16'h0001, 1'b1);
        send_sample(16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 1'b1);
        send_sample(16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1);
        send_sample(16'h0000, 16'h8000, 16'h7FFF, 16'h1234, 1'b0);
        write_reg(REG_AVERAGE_COUNT, 15'd1);
        send_sample(16'h7FFF, 16'h0000, 16'h0001, 16'h7FFF, 1'b1);
        send_sample(16'h7FFF, 16'h0000, 16'h0001, 16'h7FFF, 1'b1);
        send_sample(16'h8000, 16'h0001, 16'h0000, 16'h8000, 1'b1);
        send_sample(16'h8000, 16'h0001, 16'h0000, 16'h8000, 1'b1);
        write_reg(REG_AVERAGE_COUNT, 15'd3);
        write_reg(REG_DISCARD_COUNT, 15'h7C02);
        for (int n = 0; n < 8; n++)
            send_sample(16'h0100, 16'hFF00, 16'h4000, 16'h8000 + 16'(n), n != 4);
    endtask

    task automatic test_short_runs();
        write_reg(REG_AVERAGE_COUNT, 15'd4);
        write_reg(REG_DISCARD_COUNT, 15'd2);
        send_random(150);
        write_reg(REG_AVERAGE_COUNT, 15'd1);
        write_reg(REG_DISCARD_COUNT, 15'd0);
        send_random(150);
    endtask

    task automatic test_register_change_mid_run();
        write_reg(REG_AVERAGE_COUNT, 15'd20);
        write_reg(REG_DISCARD_COUNT, 15'd1);
        send_random(15);
        write_reg(REG_AVERAGE_COUNT, 15'd2);
        send_random(40);
        write_reg(REG_DISCARD_COUNT, 15'd1023);
        write_reg(REG_AVERAGE_COUNT, 15'd32767);
        send_random(60);
    endtask

    task automatic test_long_run();
        write_reg(REG_DISCARD_COUNT, 15'd5);
        write_reg(REG_AVERAGE_COUNT, 15'd100);
        send_random(320);
    endtask

    task automatic test_random_phases();
        int idle_set [4] = '{0, 47, 0, 12};
        int stall_set [4] = '{0, 0, 47, 12};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_AVERAGE_COUNT, 15'($urandom_range(1, 12)));
            write_reg(REG_DISCARD_COUNT, 15'($urandom_range(0, 6)));
            idle_pct = idle_set[ph];
            stall_pct = stall_set[ph];
            send_random(120);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_AVERAGE_COUNT;
        cfg_data = '0;
        fail_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        avg_len = 256;
        warmup_len = 100;
        good_ax = 0;
        good_ay = 0;
        good_az = 0;
        good_gy = 0;
        run_pos = 0;
        pitch_acc = 0;
        gyro_acc = 0;
        mean_pitch = 0;
        mean_gyro = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_short_runs();
        test_register_change_mid_run();
        test_long_run();
        test_random_phases();
        drain_results();
        if (fail_count == 0) begin
            $display("accel_pitch_offset_calibrator_top verification clean");
        end else begin
            $display("accel_pitch_offset_calibrator_top verification failed");
        end
        $finish;
    end

endmodule
